[hw/rtl/gwm_pkg.sv]
`default_nettype none

package gwm_pkg;

  // pattern geometry
  localparam int MaxPattern   = 32;
  localparam int PatternBytes = 32;
  localparam int LenW         = 6;
  localparam int QueueDepth   = 2;

  // wildcard characters
  localparam logic [7:0] StarChar = 8'h2A;
  localparam logic [7:0] AnyChar  = 8'h3F;

  // configuration register map (index = byte address / 8)
  typedef enum logic [2:0] {
    RegCharsLow     = 3'd0,
    RegCharsMidLow  = 3'd1,
    RegCharsMidHigh = 3'd2,
    RegCharsHigh    = 3'd3,
    RegLength       = 3'd4,
    RegFoldCase     = 3'd5
  } gwm_reg_e;

  // what a subject request asks of the back end
  typedef enum logic [1:0] {
    OpStep  = 2'd0,
    OpLast  = 2'd1,
    OpEmpty = 2'd2
  } gwm_op_e;

  typedef struct packed {
    gwm_op_e    op;
    logic [7:0] ch;
  } gwm_item_t;

  typedef struct packed {
    logic [PatternBytes-1:0][7:0] chars;
    logic [LenW-1:0]              length;
    logic                         fold;
  } gwm_cfg_t;

  // ascii upper case to lower case when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/glob_wildcard_matcher.sv]
`default_nettype none

// Glob matcher: subject characters stream in on s_axis and are matched against
// the configured pattern, where '*' matches any run and '?' any one character.
// One result (matched in m_axis_tdata bit 0) comes out for each character sent
// with tlast, or for each request with the empty-subject flag in tuser, which
// reports on the characters seen so far without consuming one. The block takes
// one character per clock when not stalled; that rate is set by the update of
// the live position vector (two carry-chain star closures around a bank of
// per-position byte compares). The final character passes the input register,
// queue entry and result register. Pattern registers sit at byte addresses 0,
// 8, 16 and 24 (characters 0-7 up to 24-31, first in the low byte), the length
// at 32 and case folding at 40; write them only while no subject is in flight.
module glob_wildcard_matcher #(
  parameter int MAX_PATTERN = gwm_pkg::MaxPattern
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // subject input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] subject_char
  input  wire logic        s_axis_tlast,   // last_char
  input  wire logic        s_axis_tuser,   // [0] empty_subject
  // match result
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [0] matched, [7:1] zero
);
  import gwm_pkg::*;

  logic [63:0]     chars_q [4];
  logic [LenW-1:0] length_q;
  logic            fold_q;
  logic            wr_en;
  gwm_reg_e        reg_idx;
  gwm_cfg_t        cfg;
  gwm_item_t       front_item, back_item;
  logic            front_valid, front_ready, back_valid, back_ready;
  logic            matched;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = gwm_reg_e'(paddr[5:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        chars_q[i] <= '0;
      end
      length_q <= '0;
      fold_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCharsLow:     chars_q[0] <= pwdata;
        RegCharsMidLow:  chars_q[1] <= pwdata;
        RegCharsMidHigh: chars_q[2] <= pwdata;
        RegCharsHigh:    chars_q[3] <= pwdata;
        RegLength:       length_q   <= pwdata[LenW-1:0];
        RegFoldCase:     fold_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      RegCharsLow:     prdata = chars_q[0];
      RegCharsMidLow:  prdata = chars_q[1];
      RegCharsMidHigh: prdata = chars_q[2];
      RegCharsHigh:    prdata = chars_q[3];
      RegLength:       prdata = {{(64 - LenW){1'b0}}, length_q};
      RegFoldCase:     prdata = {63'b0, fold_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg.chars  = {chars_q[3], chars_q[2], chars_q[1], chars_q[0]};
  assign cfg.length = length_q;
  assign cfg.fold   = fold_q;

  // front end: accept and classify requests
  gwm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .subject_char_i (s_axis_tdata),
    .last_char_i    (s_axis_tlast),
    .empty_subject_i(s_axis_tuser),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .item_o         (front_item),
    .item_valid_o   (front_valid),
    .item_ready_i   (front_ready)
  );

  // decoupling queue
  gwm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_item_i (front_item),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .pop_item_o  (back_item),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready)
  );

  // back end: position vector update and result
  gwm_back #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (back_item),
    .item_valid_i(back_valid),
    .item_ready_o(back_ready),
    .matched_o   (matched),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'b0, matched};

endmodule

`default_nettype wire

[hw/rtl/gwm_front.sv]
`default_nettype none

module gwm_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        subject_char_i,
  input  wire logic              last_char_i,
  input  wire logic              empty_subject_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output gwm_pkg::gwm_item_t     item_o,
  output logic                   item_valid_o,
  input  wire logic              item_ready_i
);
  import gwm_pkg::*;

  logic      valid_q;
  gwm_item_t item_q, item_d;

  // classify the incoming request
  always_comb begin
    item_d.ch = subject_char_i;
    if (empty_subject_i) begin
      item_d.op = OpEmpty;
    end else if (last_char_i) begin
      item_d.op = OpLast;
    end else begin
      item_d.op = OpStep;
    end
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gwm_queue.sv]
`default_nettype none

module gwm_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gwm_pkg::gwm_item_t push_item_i,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  output gwm_pkg::gwm_item_t      pop_item_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i
);
  import gwm_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  gwm_item_t       entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gwm_back.sv]
`default_nettype none

module gwm_back #(
  parameter int MAX_PATTERN = gwm_pkg::MaxPattern
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gwm_pkg::gwm_cfg_t  cfg_i,
  input  wire gwm_pkg::gwm_item_t item_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  output logic                    matched_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i
);
  import gwm_pkg::*;

  localparam int PosW = MAX_PATTERN + 1;

  logic [MAX_PATTERN-1:0] lim_ok, zero_ch, zero_low, char_ok, star, adv;
  logic [PosW-1:0]        mask_pos, end_oh, star_ext;
  logic [PosW-1:0]        live_q, live_d;
  logic [PosW-1:0]        v_in, b0, carry0, v0;
  logic [PosW-1:0]        nv, b1, carry1, v1;
  logic [7:0]             ch_fold;
  logic                   out_valid_q, matched_q, match_d;
  logic                   pop, finish;

  // per position pattern decode
  always_comb begin
    ch_fold = fold_byte(item_i.ch, cfg_i.fold);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      lim_ok[i]  = (LenW'(i) < cfg_i.length);
      zero_ch[i] = lim_ok[i] && (cfg_i.chars[i] == 8'h00);
      star[i]    = (cfg_i.chars[i] == StarChar);
      adv[i]     = (cfg_i.chars[i] != StarChar) &&
                   ((cfg_i.chars[i] == AnyChar) ||
                    (fold_byte(cfg_i.chars[i], cfg_i.fold) == ch_fold));
    end
  end

  // pattern ends at the first zero byte within the length
  assign zero_low = zero_ch & (~zero_ch + MAX_PATTERN'(1));
  assign char_ok  = lim_ok & (zero_low - MAX_PATTERN'(1));
  assign mask_pos = {char_ok, 1'b1};
  assign end_oh   = mask_pos & ~{1'b0, mask_pos[PosW-1:1]};
  assign star_ext = {1'b0, star & char_ok};

  // star closure as a carry chain: a star passes a live position on
  assign v_in   = live_q & mask_pos;
  assign b0     = v_in & star_ext;
  assign carry0 = (star_ext + b0) ^ star_ext ^ b0;
  assign v0     = v_in | carry0;

  // consume one character, then close again
  assign nv     = (v0 & star_ext) | {v0[MAX_PATTERN-1:0] & char_ok & adv, 1'b0};
  assign b1     = nv & star_ext;
  assign carry1 = (star_ext + b1) ^ star_ext ^ b1;
  assign v1     = nv | carry1;

  assign finish       = (item_i.op != OpStep);
  assign item_ready_o = !finish || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign match_d      = (item_i.op == OpEmpty) ? |(v0 & end_oh) : |(v1 & end_oh);
  assign live_d       = finish ? PosW'(1) : v1;

  assign matched_o   = matched_q;
  assign out_valid_o = out_valid_q;

  // live position vector and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= PosW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        live_q <= live_d;
      end
      if (pop && finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && finish) begin
      matched_q <= match_d;
    end
  end

endmodule

`default_nettype wire

[dv/gwm_match_checker.sv]
module gwm_match_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port, observed
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        pready,
  // subject requests, observed
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] subject_char
  input  wire logic        s_axis_tlast,   // last_char
  input  wire logic        s_axis_tuser,   // [0] empty_subject
  // match results, observed
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,   // [0] matched, [7:1] zero
  output int               mismatch_count_o,
  output int               pending_matches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gwm_pkg::*;

  // shadow of the pattern registers
  logic [7:0]          pattern_q [PatternBytes];
  logic [LenW-1:0]     length_q;
  logic                fold_q;
  // live pattern positions, bit i = first i pattern chars matched
  logic [MaxPattern:0] live_q;
  // expected match bits, oldest first
  logic                match_q [$];
  int                  mismatch_total;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  // pattern length in use: clamped, cut at the first zero byte
  function automatic int pattern_span();
    int lim;
    lim = (length_q > MaxPattern) ? MaxPattern : int'(length_q);
    for (int i = 0; i < lim; i++) begin
      if (pattern_q[i] == 8'h00) begin
        return i;
      end
    end
    return lim;
  endfunction

  function automatic logic [7:0] caseless(input logic [7:0] c);
    if (fold_q && c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // drop positions past the span, then let every live star skip ahead
  function automatic logic [MaxPattern:0] close_over_stars(input logic [MaxPattern:0] v,
                                                            input int span);
    logic [MaxPattern:0] r;
    r = '0;
    for (int i = 0; i <= span; i++) begin
      r[i] = v[i];
    end
    for (int i = 0; i < span; i++) begin
      if (r[i] && pattern_q[i] == StarChar) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  // one subject char: stars hold, '?' and equal chars move on
  function automatic logic [MaxPattern:0] consume_char(input logic [MaxPattern:0] v,
                                                        input int span,
                                                        input logic [7:0] c);
    logic [MaxPattern:0] nv;
    nv = '0;
    for (int i = 0; i < span; i++) begin
      if (v[i]) begin
        if (pattern_q[i] == StarChar) begin
          nv[i] = 1'b1;
        end else if (pattern_q[i] == AnyChar || caseless(pattern_q[i]) == caseless(c)) begin
          nv[i+1] = 1'b1;
        end
      end
    end
    return nv;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int span;
    logic [MaxPattern:0] v;
    logic want;
    if (!rst_ni) begin
      for (int i = 0; i < PatternBytes; i++) begin
        pattern_q[i] = 8'h00;
      end
      length_q = '0;
      fold_q = 1'b0;
      live_q = (MaxPattern + 1)'(1);
      match_q.delete();
      mismatch_total = 0;
      mismatch_count_o <= 0;
      pending_matches_o <= 0;
    end else begin
      // result side first: a result never belongs to a request of the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_q.size() == 0) begin
          report_mismatch($sformatf("result %0h with no subject pending", m_axis_tdata));
        end else begin
          want = match_q.pop_front();
          if (m_axis_tdata !== {7'b0, want}) begin
            report_mismatch($sformatf("matched got %0h want %0h", m_axis_tdata, want));
          end
        end
      end

      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegCharsLow, RegCharsMidLow, RegCharsMidHigh, RegCharsHigh: begin
            for (int b = 0; b < 8; b++) begin
              pattern_q[8 * int'(paddr[4:3]) + b] = pwdata[8*b +: 8];
            end
          end
          RegLength: begin
            length_q = pwdata[LenW-1:0];
          end
          RegFoldCase: begin
            fold_q = pwdata[0];
          end
          default: ;
        endcase
      end

      // subject request
      if (s_axis_tvalid && s_axis_tready) begin
        span = pattern_span();
        v = close_over_stars(live_q, span);
        if (s_axis_tuser) begin
          match_q.push_back(v[span]);
          live_q = (MaxPattern + 1)'(1);
        end else begin
          v = close_over_stars(consume_char(v, span, s_axis_tdata), span);
          if (s_axis_tlast) begin
            match_q.push_back(v[span]);
            live_q = (MaxPattern + 1)'(1);
          end else begin
            live_q = v;
          end
        end
      end

      mismatch_count_o <= mismatch_total;
      pending_matches_o <= match_q.size();
    end
  end

endmodule

[dv/tb_glob_wildcard_matcher.sv]
module tb_glob_wildcard_matcher;
  timeunit 1ns;
  timeprecision 1ps;
  import gwm_pkg::*;

  localparam int ItemTarget  = 1150;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int StallCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] subject_char
  logic        s_axis_tlast = 1'b0; // last_char
  logic        s_axis_tuser = 1'b0; // [0] empty_subject
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] matched, [7:1] zero
  int          mismatch_count;
  int          pending_matches;

  // stimulus state
  bit          calm = 1'b0;
  bit          stall_req = 1'b0;
  int          items_sent = 0;
  logic [7:0]  pat [MaxPattern];
  int          pat_len;
  bit          pat_fold;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  glob_wildcard_matcher i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  gwm_match_checker i_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatch_count_o(mismatch_count),
    .pending_matches_o(pending_matches)
  );

  // result sink: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // two-phase register write, bus left idle after
  task automatic reg_write(input gwm_reg_e r, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_pattern(input int len, input bit fold);
    logic [63:0] word;
    logic [2:0]  idx;
    pat_len = len;
    pat_fold = fold;
    for (int i = 0; i < 4; i++) begin
      for (int b = 0; b < 8; b++) begin
        word[8*b +: 8] = pat[8*i + b];
      end
      idx = 3'(i);
      reg_write(gwm_reg_e'(idx), word);
    end
    reg_write(RegLength, {58'b0, 6'(len)});
    reg_write(RegFoldCase, {63'b0, fold});
  endtask

  // text first, random bytes behind it
  task automatic set_text(input string s);
    for (int i = 0; i < MaxPattern; i++) begin
      pat[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
    end
  endtask

  // wait until every match has come back and the pipeline has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending_matches == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one subject request, with random gaps ahead of it
  task automatic send_req(input logic [7:0] ch, input bit last, input bit empty);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= last;
    s_axis_tuser <= empty;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_req(s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  function automatic logic [7:0] letter();
    string abc;
    abc = "abcABC";
    return abc[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] any_char();
    if ($urandom_range(99) < 70) begin
      return letter();
    end
    return 8'($urandom_range(255));
  endfunction

  // pattern chars in use, for shaping subjects
  function automatic int pattern_extent();
    int lim;
    lim = (pat_len > MaxPattern) ? MaxPattern : pat_len;
    for (int i = 0; i < lim; i++) begin
      if (pat[i] == 8'h00) begin
        return i;
      end
    end
    return lim;
  endfunction

  task automatic random_pattern();
    int r;
    int k;
    int len;
    r = $urandom_range(99);
    len = (r < 70) ? $urandom_range(0, 6) : (r < 92) ? $urandom_range(7, 32)
                                                     : $urandom_range(33, 63);
    for (int i = 0; i < MaxPattern; i++) begin
      k = $urandom_range(99);
      pat[i] = (k < 45) ? letter() : (k < 65) ? StarChar : (k < 82) ? AnyChar :
               (k < 98) ? 8'($urandom_range(1, 255)) : 8'h00;
    end
    write_pattern(len, 1'($urandom_range(1)));
  endtask

  // subject built to fit the pattern, sometimes broken or plain random
  task automatic send_subject();
    logic [7:0] subj [$];
    logic [7:0] c;
    int n;
    int pos;
    n = pattern_extent();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(0, 6)) subj.push_back(any_char());
    end else begin
      for (int i = 0; i < n; i++) begin
        c = pat[i];
        if (c == StarChar) begin
          repeat ($urandom_range(0, 3)) subj.push_back(any_char());
        end else if (c == AnyChar) begin
          subj.push_back(any_char());
        end else begin
          if (pat_fold && $urandom_range(1) == 1 &&
              ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) begin
            c = c ^ 8'h20;
          end
          subj.push_back(c);
        end
      end
      if ($urandom_range(99) < 25) begin
        pos = (subj.size() == 0) ? 0 : $urandom_range(subj.size() - 1);
        case ($urandom_range(2))
          0: subj.insert(pos, any_char());
          1: if (subj.size() > 0) subj.delete(pos);
          default: if (subj.size() > 0) subj[pos] = any_char();
        endcase
      end
    end

    if (subj.size() == 0) begin
      send_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end else begin
      for (int i = 0; i < subj.size(); i++) begin
        send_req(subj[i], i == subj.size() - 1, 1'b0);
        // an empty mark in the middle reports early and restarts
        if (i < subj.size() - 1 && $urandom_range(99) < 3) begin
          send_req(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
      end
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is empty: empty subject matches, one char does not
    send_req(8'h5A, 1'b0, 1'b1);
    send_text("x");

    // star and any with case folding
    settle();
    set_text("a*B?");
    write_pattern(4, 1'b1);
    send_text("Axxbz");
    send_text("ab");

    // zero and top-value subject chars against a single any
    settle();
    set_text("?");
    write_pattern(1, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);

    // full width of stars, length register above the maximum
    settle();
    for (int i = 0; i < MaxPattern; i++) begin
      pat[i] = StarChar;
    end
    write_pattern(63, 1'b0);
    send_text("q");
    send_req(8'hA5, 1'b1, 1'b1);

    // zero byte cuts the pattern short
    settle();
    set_text("ab?cd");
    pat[2] = 8'h00;
    write_pattern(5, 1'b0);
    send_text("ab");

    // folding touches letters only: '@' is not '`'
    settle();
    set_text("@Z");
    write_pattern(2, 1'b1);
    send_text("`z");

    // length shrunk in the middle of a subject
    settle();
    set_text("abcd");
    write_pattern(4, 1'b0);
    send_req("a", 1'b0, 1'b0);
    send_req("b", 1'b0, 1'b0);
    settle();
    reg_write(RegLength, 64'd2);
    send_req(8'h00, 1'b1, 1'b1);

    // random phases, each with its own pattern
    phase = 0;
    while (items_sent < ItemTarget) begin
      settle();
      random_pattern();
      calm = (phase >= 8 && phase < 14);
      if (phase == 4) begin
        stall_req = 1'b1;
      end
      repeat ($urandom_range(5, 25)) send_subject();
      phase++;
    end

    settle();
    if (mismatch_count == 0 && pending_matches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
